// ===== hdl/i4qdp_pkg.sv =====
package i4qdp_pkg;

    localparam int LANES = 4;

    // Width of the working frame of the floating-point unit.
    localparam int FW = 80;

    localparam logic [31:0] F32_NEG_ZERO = 32'h8000_0000;
    localparam logic [31:0] F32_ONE      = 32'h3F80_0000;
    localparam logic [31:0] F32_DEF_NAN  = 32'hFFC0_0000;
    localparam logic [31:0] F32_QNAN_BIT = 32'h0040_0000;

    typedef enum logic [1:0] {
        REG_GROUP_SIZE = 2'd0,
        REG_ACT_SCALE  = 2'd1,
        REG_ZERO_POINT = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [31:0] acc;
        logic [31:0] outer_scale;
        logic [31:0] ksum;
        logic        first;
        logic        last;
    } grp_entry_t;

    typedef struct packed {
        logic start;
        logic int_mode;
        logic neg_c;
    } fma_ctl_t;

    typedef struct packed {
        logic               sign;
        logic               nan;
        logic               inf;
        logic               zero;
        logic [23:0]        mant;
        logic signed [11:0] lsb;
    } fp_unpacked_t;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_MUL,
        FS_ALIGN,
        FS_ADD,
        FS_NORM,
        FS_ROUND,
        FS_DONE
    } fma_state_t;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_CONV,
        BS_GROUP,
        BS_KZ,
        BS_SUB,
        BS_SCALE,
        BS_OUT
    } back_state_t;

    function automatic fp_unpacked_t unpack_f32(input logic [31:0] v);
        fp_unpacked_t u;
        logic [7:0]   e1;
        u.sign = v[31];
        u.nan  = (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
        u.inf  = (v[30:23] == 8'hFF) && (v[22:0] == 23'd0);
        u.zero = (v[30:0] == 31'd0);
        u.mant = {(v[30:23] != 8'd0), v[22:0]};
        e1     = (v[30:23] == 8'd0) ? 8'd1 : v[30:23];
        // Weight of the mantissa LSB, as a power of two.
        u.lsb  = $signed({4'b0000, e1}) - 12'sd150;
        return u;
    endfunction

    // Right shift that ORs every bit shifted out into the LSB.
    function automatic logic [FW-1:0] jam_shr(input logic [FW-1:0] v, input logic [6:0] s);
        logic [FW-1:0] mask;
        mask = ~({FW{1'b1}} << s);
        return (v >> s) | FW'(|(v & mask));
    endfunction

    function automatic logic [31:0] i8_to_f32(input logic signed [7:0] v);
        logic [7:0]  mag;
        logic [2:0]  pos;
        logic [22:0] frac;
        logic [7:0]  ex;
        mag = v[7] ? 8'(-v) : 8'(v);
        pos = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (mag[i]) begin
                pos = 3'(i);
            end
        end
        frac = 23'({15'd0, mag} << (5'd23 - {2'b00, pos}));
        ex   = 8'd127 + {5'd0, pos};
        return (mag == 8'd0) ? 32'd0 : {v[7], ex, frac};
    endfunction

endpackage

// ===== hdl/int4_two_level_quant_dot_product.sv =====
// Items are taken one per cycle while the group queue has room.
// A group close costs the back end an integer conversion and one
// fused multiply-add pass; the last item costs three more passes.
// Reset is asynchronous and active low; it clears the control state and loads the
// registers with a group size of 32, an activation scale of 1.0 and zero point 0.
module int4_two_level_quant_dot_product
    import i4qdp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic signed [7:0] act_a,
    input  logic signed [7:0] act_b,
    input  logic signed [7:0] act_c,
    input  logic signed [7:0] act_d,
    input  logic signed [3:0] wt_a,
    input  logic signed [3:0] wt_b,
    input  logic signed [3:0] wt_c,
    input  logic signed [3:0] wt_d,
    input  logic signed [7:0] inner_scale,
    input  logic [31:0]       outer_scale_bits,
    input  logic [31:0]       weight_ksum_bits,
    input  logic              last,
    output logic              empty,
    input  logic              pop,
    output logic [31:0]       result_bits,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data
);

    logic [12:0]       group_size_reg, group_size_next;
    logic [31:0]       act_scale_reg, act_scale_next;
    logic signed [7:0] zero_point_reg, zero_point_next;

    logic              q_push, q_full, q_pop, q_empty;
    grp_entry_t        q_wdata, q_rdata;
    fma_ctl_t          fctl;
    logic [31:0]       fa, fb, fc, fint, fres;
    logic              fdone;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        group_size_next = group_size_reg;
        act_scale_next  = act_scale_reg;
        zero_point_next = zero_point_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_GROUP_SIZE: group_size_next = cfg_data[12:0];
                REG_ACT_SCALE:  act_scale_next  = cfg_data;
                REG_ZERO_POINT: zero_point_next = $signed(cfg_data[7:0]);
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_size_reg <= 13'd32;
            act_scale_reg  <= F32_ONE;
            zero_point_reg <= 8'sd0;
        end
        else
        begin
            group_size_reg <= group_size_next;
            act_scale_reg  <= act_scale_next;
            zero_point_reg <= zero_point_next;
        end
    end

    i4qdp_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .act_a            (act_a),
        .act_b            (act_b),
        .act_c            (act_c),
        .act_d            (act_d),
        .wt_a             (wt_a),
        .wt_b             (wt_b),
        .wt_c             (wt_c),
        .wt_d             (wt_d),
        .inner_scale      (inner_scale),
        .outer_scale_bits (outer_scale_bits),
        .weight_ksum_bits (weight_ksum_bits),
        .last             (last),
        .group_size       (group_size_reg),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_data           (q_wdata)
    );

    i4qdp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    i4qdp_fma u_fma (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (fctl),
        .a_bits  (fa),
        .b_bits  (fb),
        .c_bits  (fc),
        .int_val (fint),
        .done    (fdone),
        .res     (fres)
    );

    i4qdp_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_pop          (q_pop),
        .q_data         (q_rdata),
        .act_scale_bits (act_scale_reg),
        .act_zero_point (zero_point_reg),
        .fctl           (fctl),
        .fa             (fa),
        .fb             (fb),
        .fc             (fc),
        .fint           (fint),
        .fdone          (fdone),
        .fres           (fres),
        .empty          (empty),
        .pop            (pop),
        .result_bits    (result_bits)
    );

endmodule

// ===== hdl/i4qdp_fifo.sv =====
module i4qdp_fifo
    import i4qdp_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  grp_entry_t wdata,
    output logic       full,
    input  logic       pop,
    output grp_entry_t rdata,
    output logic       empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    grp_entry_t      mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hdl/i4qdp_front.sv =====
module i4qdp_front
    import i4qdp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [7:0]  act_a,
    input  logic signed [7:0]  act_b,
    input  logic signed [7:0]  act_c,
    input  logic signed [7:0]  act_d,
    input  logic signed [3:0]  wt_a,
    input  logic signed [3:0]  wt_b,
    input  logic signed [3:0]  wt_c,
    input  logic signed [3:0]  wt_d,
    input  logic signed [7:0]  inner_scale,
    input  logic [31:0]        outer_scale_bits,
    input  logic [31:0]        weight_ksum_bits,
    input  logic               last,
    input  logic [12:0]        group_size,
    input  logic               q_full,
    output logic               q_push,
    output grp_entry_t         q_data
);

    logic signed [7:0] act_v [LANES];
    logic signed [3:0] wt_v  [LANES];
    logic [31:0]       acc_reg, acc_next;
    logic [11:0]       count_reg, count_next;
    logic              first_reg, first_next;
    logic [31:0]       acc_sum;
    logic [10:0]       items;
    logic [11:0]       cnt_inc;
    logic              accept, close;

    assign act_v[0] = act_a;
    assign act_v[1] = act_b;
    assign act_v[2] = act_c;
    assign act_v[3] = act_d;
    assign wt_v[0]  = wt_a;
    assign wt_v[1]  = wt_b;
    assign wt_v[2]  = wt_c;
    assign wt_v[3]  = wt_d;

    // Each weight is scaled with 8-bit wraparound before meeting its activation.
    always_comb
    begin
        logic signed [11:0] wprod;
        logic signed [7:0]  ws;
        logic signed [15:0] lp;
        logic [31:0]        sum;
        sum = 32'd0;
        for (int i = 0; i < LANES; i++)
        begin
            wprod = 12'(wt_v[i]) * 12'(inner_scale);
            ws    = $signed(wprod[7:0]);
            lp    = 16'(act_v[i]) * 16'(ws);
            sum   = sum + 32'(lp);
        end
        acc_sum = acc_reg + sum;
    end

    assign items   = (group_size[12:2] == 11'd0) ? 11'd1 : group_size[12:2];
    assign cnt_inc = count_reg + 12'd1;
    assign close   = (cnt_inc >= {1'b0, items}) || (cnt_inc == 12'd0) || last;
    assign accept  = push && !q_full;
    assign full    = q_full;
    assign q_push  = accept && close;

    always_comb
    begin
        q_data.acc         = acc_sum;
        q_data.outer_scale = outer_scale_bits;
        q_data.ksum        = weight_ksum_bits;
        q_data.first       = first_reg;
        q_data.last        = last;
    end

    always_comb
    begin
        acc_next   = acc_reg;
        count_next = count_reg;
        first_next = first_reg;
        if (accept)
        begin
            if (close)
            begin
                acc_next   = 32'd0;
                count_next = 12'd0;
                first_next = last;
            end
            else
            begin
                acc_next   = acc_sum;
                count_next = cnt_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= 32'd0;
            count_reg <= 12'd0;
            first_reg <= 1'b1;
        end
        else
        begin
            acc_reg   <= acc_next;
            count_reg <= count_next;
            first_reg <= first_next;
        end
    end

endmodule

// ===== hdl/i4qdp_fma.sv =====
module i4qdp_fma
    import i4qdp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  fma_ctl_t    ctl,
    input  logic [31:0] a_bits,
    input  logic [31:0] b_bits,
    input  logic [31:0] c_bits,
    input  logic [31:0] int_val,
    output logic        done,
    output logic [31:0] res
);

    fma_state_t         state_reg, state_next;
    logic               psign_reg, psign_next;
    logic               csign_reg, csign_next;
    logic               rsign_reg, rsign_next;
    logic [23:0]        ma_reg, ma_next;
    logic [23:0]        mb_reg, mb_next;
    logic [23:0]        mc_reg, mc_next;
    logic signed [11:0] ep_reg, ep_next;
    logic signed [11:0] ec_reg, ec_next;
    logic [47:0]        prod_reg, prod_next;
    logic [FW-1:0]      pf_reg, pf_next;
    logic [FW-1:0]      cf_reg, cf_next;
    logic [FW-1:0]      m_reg, m_next;
    logic signed [11:0] e_reg, e_next;
    logic [31:0]        res_reg, res_next;

    fp_unpacked_t       ua, ub, uc;
    logic               in_psign, in_csign;
    logic               spec;
    logic [31:0]        spec_res;
    logic [31:0]        int_mag;

    logic [FW-1:0]      al_pf, al_cf;
    logic signed [11:0] al_e;

    logic [FW-1:0]      add_mag;
    logic               add_sign, add_zero, zero_sign;

    logic [3:0]         lz;

    logic [31:0]        round_res;

    assign ua       = unpack_f32(a_bits);
    assign ub       = unpack_f32(b_bits);
    assign uc       = unpack_f32(c_bits);
    assign in_psign = ua.sign ^ ub.sign;
    assign in_csign = uc.sign ^ ctl.neg_c;
    assign int_mag  = int_val[31] ? (~int_val + 32'd1) : int_val;

    // NaN operands propagate in operand order; an invalid product is formed before
    // the addend is looked at, so it yields the default NaN even over a NaN addend.
    always_comb
    begin
        spec     = 1'b1;
        spec_res = F32_DEF_NAN;
        priority if (ua.nan)
        begin
            spec_res = a_bits | F32_QNAN_BIT;
        end
        else if (ub.nan)
        begin
            spec_res = b_bits | F32_QNAN_BIT;
        end
        else if ((ua.inf && ub.zero) || (ua.zero && ub.inf))
        begin
            spec_res = F32_DEF_NAN;
        end
        else if (uc.nan)
        begin
            spec_res = c_bits | F32_QNAN_BIT;
        end
        else if (ua.inf || ub.inf)
        begin
            if (uc.inf && (in_csign != in_psign))
            begin
                spec_res = F32_DEF_NAN;
            end
            else
            begin
                spec_res = {in_psign, 8'hFF, 23'd0};
            end
        end
        else if (uc.inf)
        begin
            spec_res = {in_csign, 8'hFF, 23'd0};
        end
        else
        begin
            spec = 1'b0;
        end
    end

    // The frame LSB sits two bits below the product LSB. An addend far above
    // the product pushes the product down into the sticky bit instead.
    always_comb
    begin
        logic signed [11:0] pos;
        logic signed [11:0] sp;
        logic signed [11:0] npos;
        logic [6:0]         amt;
        logic [FW-1:0]      pbase;
        logic [FW-1:0]      cbase;
        pos   = ec_reg - ep_reg + 12'sd2;
        sp    = pos - 12'sd54;
        npos  = -pos;
        pbase = {30'd0, prod_reg, 2'b00};
        cbase = {56'd0, mc_reg};
        amt   = 7'd0;
        al_pf = pbase;
        al_cf = cbase;
        al_e  = ep_reg - 12'sd2;
        if (pos > 12'sd54)
        begin
            amt   = (sp > 12'sd63) ? 7'd63 : sp[6:0];
            al_pf = jam_shr(pbase, amt);
            al_cf = cbase << 54;
            al_e  = ep_reg - 12'sd2 + sp;
        end
        else if (pos >= 12'sd0)
        begin
            al_cf = cbase << pos[6:0];
        end
        else
        begin
            amt   = (npos > 12'sd63) ? 7'd63 : npos[6:0];
            al_cf = jam_shr(cbase, amt);
        end
    end

    always_comb
    begin
        if (psign_reg == csign_reg)
        begin
            add_mag  = pf_reg + cf_reg;
            add_sign = psign_reg;
        end
        else if (pf_reg >= cf_reg)
        begin
            add_mag  = pf_reg - cf_reg;
            add_sign = psign_reg;
        end
        else
        begin
            add_mag  = cf_reg - pf_reg;
            add_sign = csign_reg;
        end
        add_zero  = (add_mag == '0);
        zero_sign = (psign_reg == csign_reg) ? psign_reg : 1'b0;
    end

    always_comb
    begin
        lz = 4'd8;
        for (int i = 0; i < 8; i++)
        begin
            if (m_reg[FW-8+i])
            begin
                lz = 4'(7 - i);
            end
        end
    end

    always_comb
    begin
        logic signed [11:0] be;
        logic signed [11:0] sh;
        logic [4:0]         s;
        logic [FW-1:0]      t;
        logic [7:0]         expf;
        logic [22:0]        frac;
        logic               guard, sticky, rnd;
        logic [30:0]        body;
        be     = e_reg + 12'sd206;
        sh     = 12'sd1 - be;
        if (be >= 12'sd1)
        begin
            s = 5'd0;
        end
        else if (sh > 12'sd31)
        begin
            s = 5'd31;
        end
        else
        begin
            s = sh[4:0];
        end
        t      = jam_shr(m_reg, {2'b00, s});
        expf   = (be >= 12'sd1) ? be[7:0] : 8'd0;
        frac   = t[FW-2:FW-24];
        guard  = t[FW-25];
        sticky = |t[FW-26:0];
        rnd    = guard && (sticky || frac[0]);
        body   = {expf, frac} + 31'(rnd);
        if (be >= 12'sd255)
        begin
            round_res = {rsign_reg, 8'hFF, 23'd0};
        end
        else
        begin
            round_res = {rsign_reg, body};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FS_IDLE:
            begin
                if (ctl.start)
                begin
                    if (ctl.int_mode)
                    begin
                        state_next = (int_val == 32'd0) ? FS_DONE : FS_NORM;
                    end
                    else
                    begin
                        state_next = spec ? FS_DONE : FS_MUL;
                    end
                end
            end
            FS_MUL:   state_next = FS_ALIGN;
            FS_ALIGN: state_next = FS_ADD;
            FS_ADD:   state_next = add_zero ? FS_DONE : FS_NORM;
            FS_NORM:  state_next = m_reg[FW-1] ? FS_ROUND : FS_NORM;
            FS_ROUND: state_next = FS_DONE;
            FS_DONE:  state_next = FS_IDLE;
            default:  state_next = FS_IDLE;
        endcase
    end

    always_comb
    begin
        psign_next = psign_reg;
        csign_next = csign_reg;
        rsign_next = rsign_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        mc_next    = mc_reg;
        ep_next    = ep_reg;
        ec_next    = ec_reg;
        prod_next  = prod_reg;
        pf_next    = pf_reg;
        cf_next    = cf_reg;
        m_next     = m_reg;
        e_next     = e_reg;
        res_next   = res_reg;
        unique case (state_reg)
            FS_IDLE:
            begin
                if (ctl.start)
                begin
                    if (ctl.int_mode)
                    begin
                        m_next     = FW'(int_mag);
                        e_next     = 12'sd0;
                        rsign_next = int_val[31];
                        res_next   = 32'd0;
                    end
                    else
                    begin
                        res_next   = spec_res;
                        psign_next = in_psign;
                        csign_next = in_csign;
                        ma_next    = ua.mant;
                        mb_next    = ub.mant;
                        mc_next    = uc.mant;
                        ep_next    = ua.lsb + ub.lsb;
                        ec_next    = uc.lsb;
                    end
                end
            end
            FS_MUL:
            begin
                prod_next = ma_reg * mb_reg;
            end
            FS_ALIGN:
            begin
                pf_next = al_pf;
                cf_next = al_cf;
                e_next  = al_e;
            end
            FS_ADD:
            begin
                m_next     = add_mag;
                rsign_next = add_sign;
                res_next   = {zero_sign, 31'd0};
            end
            FS_NORM:
            begin
                if (!m_reg[FW-1])
                begin
                    m_next = m_reg << lz;
                    e_next = e_reg - 12'(lz);
                end
            end
            FS_ROUND:
            begin
                res_next = round_res;
            end
            FS_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign done = (state_reg == FS_DONE);
    assign res  = res_reg;

    always_ff @(posedge clk)
    begin
        psign_reg <= psign_next;
        csign_reg <= csign_next;
        rsign_reg <= rsign_next;
        ma_reg    <= ma_next;
        mb_reg    <= mb_next;
        mc_reg    <= mc_next;
        ep_reg    <= ep_next;
        ec_reg    <= ec_next;
        prod_reg  <= prod_next;
        pf_reg    <= pf_next;
        cf_reg    <= cf_next;
        m_reg     <= m_next;
        e_reg     <= e_next;
        res_reg   <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/i4qdp_back.sv =====
module i4qdp_back
    import i4qdp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    output logic              q_pop,
    input  grp_entry_t        q_data,
    input  logic [31:0]       act_scale_bits,
    input  logic signed [7:0] act_zero_point,
    output fma_ctl_t          fctl,
    output logic [31:0]       fa,
    output logic [31:0]       fb,
    output logic [31:0]       fc,
    output logic [31:0]       fint,
    input  logic              fdone,
    input  logic [31:0]       fres,
    output logic              empty,
    input  logic              pop,
    output logic [31:0]       result_bits
);

    back_state_t state_reg, state_next;
    logic        wait_reg, wait_next;
    grp_entry_t  ent_reg, ent_next;
    logic [31:0] sum_reg, sum_next;
    logic [31:0] tmp_reg, tmp_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_data_reg, out_data_next;
    logic        op_state;

    assign op_state = (state_reg == BS_CONV) || (state_reg == BS_GROUP) ||
                      (state_reg == BS_KZ) || (state_reg == BS_SUB) ||
                      (state_reg == BS_SCALE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BS_IDLE:  if (!q_empty) state_next = BS_CONV;
            BS_CONV:  if (fdone) state_next = BS_GROUP;
            BS_GROUP:
            begin
                if (fdone)
                begin
                    state_next = ent_reg.last ? BS_KZ : BS_IDLE;
                end
            end
            BS_KZ:    if (fdone) state_next = BS_SUB;
            BS_SUB:   if (fdone) state_next = BS_SCALE;
            BS_SCALE: if (fdone) state_next = BS_OUT;
            BS_OUT:   if (!out_valid_reg) state_next = BS_IDLE;
            default:  state_next = BS_IDLE;
        endcase
    end

    // Each step issues one operation to the shared unit and waits for its result.
    always_comb
    begin
        q_pop         = (state_reg == BS_IDLE) && !q_empty;
        fctl.start    = op_state && !wait_reg;
        fctl.int_mode = (state_reg == BS_CONV);
        fctl.neg_c    = (state_reg == BS_SUB);
        fint          = ent_reg.acc;
        fa            = tmp_reg;
        fb            = ent_reg.outer_scale;
        fc            = F32_NEG_ZERO;
        unique case (state_reg)
            BS_GROUP:
            begin
                fa = tmp_reg;
                fb = ent_reg.outer_scale;
                fc = ent_reg.first ? F32_NEG_ZERO : sum_reg;
            end
            BS_KZ:
            begin
                fa = ent_reg.ksum;
                fb = i8_to_f32(act_zero_point);
            end
            BS_SUB:
            begin
                fa = sum_reg;
                fb = F32_ONE;
                fc = tmp_reg;
            end
            BS_SCALE:
            begin
                fa = tmp_reg;
                fb = act_scale_bits;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        wait_next      = wait_reg;
        ent_next       = ent_reg;
        sum_next       = sum_reg;
        tmp_next       = tmp_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (q_pop)
        begin
            ent_next = q_data;
        end
        if (op_state)
        begin
            if (fdone)
            begin
                wait_next = 1'b0;
                if (state_reg == BS_GROUP)
                begin
                    sum_next = fres;
                end
                else
                begin
                    tmp_next = fres;
                end
            end
            else
            begin
                wait_next = 1'b1;
            end
        end
        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
        if ((state_reg == BS_OUT) && !out_valid_reg)
        begin
            out_valid_next = 1'b1;
            out_data_next  = tmp_reg;
        end
    end

    assign empty       = !out_valid_reg;
    assign result_bits = out_data_reg;

    always_ff @(posedge clk)
    begin
        ent_reg      <= ent_next;
        sum_reg      <= sum_next;
        tmp_reg      <= tmp_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BS_IDLE;
            wait_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wait_reg      <= wait_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hdl/i4qdp_checker.sv =====
module i4qdp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        push,
    input logic        full,
    input logic        last,
    input logic        empty,
    input logic        pop,
    input logic [31:0] result_bits,
    input logic        cfg_valid,
    input logic        cfg_ready
);

    // No result is pending while reset is held.
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result queue not empty during reset");

    // A waiting result stays and holds its value until it is taken.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result_bits)))
        else $error("waiting result changed or vanished");

    // A result that was just taken cannot be replaced in the same cycle.
    a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop) |=> empty)
        else $error("result queue refilled without a new result");

    // Configuration writes are never stalled.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind int4_two_level_quant_dot_product i4qdp_checker u_i4qdp_checker (.*);
